// File: src/gcb_pkg.sv
// Shared constants, widths and the CORDIC arctangent table for the great-circle bearing unit.
// No dependencies; every other file of the block imports this package.
package gcb_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	// Widths of the sine/cosine datapath, its angle accumulator and the vectoring datapath.
	localparam int SC_W  = 33;
	localparam int SZ_W  = 34;
	localparam int VEC_W = 64;

	localparam logic signed [SC_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [SC_W-1:0] Q30_ONE     = 33'sd1073741824;

	// round(2^64 / 3600000000), the reciprocal used to estimate the binary angle.
	localparam logic [32:0] RECIP_K    = 33'd5124095576;
	localparam logic [31:0] TURN_UNITS = 32'd3600000000;
	localparam logic [31:0] HALF_TURN  = 32'd1800000000;
	localparam logic [31:0] EST_ROUND  = 32'h8000_0000;

	localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;
	localparam logic [31:0] HALF_ANGLE  = 32'h8000_0000;
	localparam logic [24:0] FULL_CIRCLE = 25'd23592960;

	// atan(2^-k) in binary-angle units, 2^32 to one turn.
	function automatic logic [31:0] atan_at(input int k);
		logic [31:0] r;
		unique case (k)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// File: src/great_circle_bearing_unit.sv
// Initial great-circle bearing. Throughput is one transfer per cycle unless stalled;
// every stage, including each CORDIC cell, is one register.
// The whole pipeline advances together and holds while a finished bearing waits on out_ready.
// Reset (arst_n low, asynchronous) clears only the stage valid bits; datapath registers keep
// whatever they hold, and out_valid stays low until a new item has crossed the pipeline.
module great_circle_bearing_unit #(
	parameter int CORDIC_STEPS = gcb_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [30:0] from_lat,
	input  logic [31:0] from_lon,
	input  logic [30:0] to_lat,
	input  logic [31:0] to_lon,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [24:0] course_angle
);
	import gcb_pkg::*;

	localparam int LAT = 2 * CORDIC_STEPS + 12;

	logic en;
	logic [LAT-1:0] vld_q;

	logic [31:0] t1, l1, t2, l2, dlon;
	logic signed [SC_W-1:0] c1, s1, c2, s2, cd, sd;

	logic signed [VEC_W-1:0] p_y, p_a, p_b, p_bc, vx_full;
	logic signed [VEC_W-1:0] y_s1;
	logic signed [SZ_W-1:0]  a_s1, b_s1;
	logic signed [SC_W-1:0]  cd_s1;
	logic signed [VEC_W-1:0] y_s2, bc_s2;
	logic signed [SZ_W-1:0]  a_s2;
	logic signed [VEC_W-1:0] vx_s3, vy_s3;
	logic signed [VEC_W-1:0] vx0_s4, vy0_s4;
	logic                    xneg, yzero;

	logic signed [VEC_W-1:0] vx_p [CORDIC_STEPS+1];
	logic signed [VEC_W-1:0] vy_p [CORDIC_STEPS+1];
	logic [31:0]             vz_p [CORDIC_STEPS+1];
	logic                    half_p [CORDIC_STEPS+1];
	logic                    yz_p   [CORDIC_STEPS+1];

	logic [31:0] ang, ang_s5;
	logic [40:0] scaled;
	logic [24:0] deg, course_s6;

	// A transfer into the pipeline happens whenever the output register is free or being read.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[LAT-1];

	// Coordinates to binary angles.
	gcb_turn u_t1 (.clk(clk), .en(en), .coord({from_lat[30], from_lat}), .turn(t1));
	gcb_turn u_l1 (.clk(clk), .en(en), .coord(from_lon), .turn(l1));
	gcb_turn u_t2 (.clk(clk), .en(en), .coord({to_lat[30], to_lat}), .turn(t2));
	gcb_turn u_l2 (.clk(clk), .en(en), .coord(to_lon), .turn(l2));

	// Longitude difference wraps modulo one turn.
	assign dlon = l2 - l1;

	gcb_sincos #(.STEPS(CORDIC_STEPS)) u_sc1 (
		.clk(clk), .en(en), .ang(t1), .cos_q(c1), .sin_q(s1)
	);
	gcb_sincos #(.STEPS(CORDIC_STEPS)) u_sc2 (
		.clk(clk), .en(en), .ang(t2), .cos_q(c2), .sin_q(s2)
	);
	gcb_sincos #(.STEPS(CORDIC_STEPS)) u_scd (
		.clk(clk), .en(en), .ang(dlon), .cos_q(cd), .sin_q(sd)
	);

	// Spherical terms. Stage 1 forms y in Q60 and the Q30 products a and b; stage 2
	// multiplies b by cos(dlon); stage 3 subtracts and drops to Q58.
	assign p_y  = VEC_W'(sd) * VEC_W'(c2);
	assign p_a  = VEC_W'(c1) * VEC_W'(s2);
	assign p_b  = VEC_W'(s1) * VEC_W'(c2);
	assign p_bc = VEC_W'(b_s1) * VEC_W'(cd_s1);
	assign vx_full = (VEC_W'(a_s2) <<< 30) - bc_s2;

	// Vectoring setup: a vector pointing left is turned by half a turn first.
	assign xneg  = vx_s3 < 0;
	assign yzero = vy_s3 == '0;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1   <= p_y;
			a_s1   <= SZ_W'(p_a >>> 30);
			b_s1   <= SZ_W'(p_b >>> 30);
			cd_s1  <= cd;
			y_s2   <= y_s1;
			a_s2   <= a_s1;
			bc_s2  <= p_bc;
			vx_s3  <= vx_full >>> 2;
			vy_s3  <= y_s2 >>> 2;
			vx0_s4 <= xneg ? -vx_s3 : vx_s3;
			vy0_s4 <= xneg ? -vy_s3 : vy_s3;
			half_p[0] <= xneg;
			yz_p[0]   <= yzero;
			for (int i = 1; i <= CORDIC_STEPS; i++) begin
				half_p[i] <= half_p[i-1];
				yz_p[i]   <= yz_p[i-1];
			end
		end
	end

	assign vx_p[0] = vx0_s4;
	assign vy_p[0] = vy0_s4;
	assign vz_p[0] = '0;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
		gcb_vec_cell #(.SHIFT(g)) u_cell (
			.clk  (clk),
			.en   (en),
			.x_in (vx_p[g]),
			.y_in (vy_p[g]),
			.z_in (vz_p[g]),
			.x_q  (vx_p[g+1]),
			.y_q  (vy_p[g+1]),
			.z_q  (vz_p[g+1])
		);
	end

	// A zero y gives exactly 0 or 180 degrees; otherwise the accumulated angle is added
	// to the half-turn offset.
	assign ang = (half_p[CORDIC_STEPS] ? HALF_ANGLE : 32'h0)
		+ (yz_p[CORDIC_STEPS] ? 32'h0 : vz_p[CORDIC_STEPS]);

	// Scale by 360 (256 + 64 + 32 + 8), round half up, fold a full circle back to zero.
	assign scaled = {1'b0, ang_s5, 8'h0} + {3'b0, ang_s5, 6'h0} + {4'b0, ang_s5, 5'h0}
		+ {6'b0, ang_s5, 3'h0} + 41'd32768;
	assign deg = scaled[40:16];

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s5    <= ang;
			course_s6 <= (deg >= FULL_CIRCLE) ? (deg - FULL_CIRCLE) : deg;
		end
	end

	assign course_angle = course_s6;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output register is empty");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while the pipeline is stalled");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (course_angle < FULL_CIRCLE))
		else $error("bearing not wrapped below a full circle");
`endif

endmodule

// File: src/gcb_turn.sv
// Four-stage conversion of a coordinate in 1e-7 degree to a 32-bit binary angle.
// Depends on gcb_pkg for the reciprocal and turn constants.
module gcb_turn (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] coord,
	output logic [31:0] turn
);
	import gcb_pkg::*;

	logic [31:0] mag_s1;
	logic        neg_s1;
	logic [64:0] est_full;
	logic [31:0] est_s2, mag_s2;
	logic        neg_s2;
	logic [63:0] prod_s3;
	logic [31:0] est_s3, mag_s3;
	logic        neg_s3;
	logic signed [65:0] rem;
	logic [31:0] quo;
	logic [31:0] turn_s4;

	// The estimate is within one of the rounded quotient; the remainder settles it.
	assign est_full = 65'(mag_s1) * 65'(RECIP_K) + 65'(EST_ROUND);
	assign rem = $signed({2'b00, mag_s3, 32'h0}) + $signed(66'(HALF_TURN))
		- $signed({2'b00, prod_s3});

	always_comb begin
		if (rem < 66'sd0) begin
			quo = est_s3 - 32'd1;
		end else if (rem >= $signed(66'(TURN_UNITS))) begin
			quo = est_s3 + 32'd1;
		end else begin
			quo = est_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= coord[31];
			mag_s1  <= coord[31] ? (32'd0 - coord) : coord;
			est_s2  <= est_full[63:32];
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			prod_s3 <= 64'(est_s2) * 64'(TURN_UNITS);
			est_s3  <= est_s2;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			turn_s4 <= neg_s3 ? (32'd0 - quo) : quo;
		end
	end

	assign turn = turn_s4;

endmodule

// File: src/gcb_rot_cell.sv
// One rotation-mode CORDIC cell with a fixed shift, registered outputs.
// Depends on gcb_pkg for widths and the arctangent table.
module gcb_rot_cell #(
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [gcb_pkg::SC_W-1:0] x_in,
	input  logic signed [gcb_pkg::SC_W-1:0] y_in,
	input  logic signed [gcb_pkg::SZ_W-1:0] z_in,
	output logic signed [gcb_pkg::SC_W-1:0] x_q,
	output logic signed [gcb_pkg::SC_W-1:0] y_q,
	output logic signed [gcb_pkg::SZ_W-1:0] z_q
);
	import gcb_pkg::*;

	localparam logic signed [SZ_W-1:0] ATAN = $signed(SZ_W'(atan_at(SHIFT)));

	logic signed [SC_W-1:0] xs, ys;

	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_in >= 0) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end
		end
	end

endmodule

// File: src/gcb_vec_cell.sv
// One vectoring-mode CORDIC cell with a fixed shift, registered outputs.
// Depends on gcb_pkg for widths and the arctangent table.
module gcb_vec_cell #(
	parameter int SHIFT = 0
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [gcb_pkg::VEC_W-1:0] x_in,
	input  logic signed [gcb_pkg::VEC_W-1:0] y_in,
	input  logic [31:0]                    z_in,
	output logic signed [gcb_pkg::VEC_W-1:0] x_q,
	output logic signed [gcb_pkg::VEC_W-1:0] y_q,
	output logic [31:0]                    z_q
);
	import gcb_pkg::*;

	localparam logic [31:0] ATAN = atan_at(SHIFT);

	logic signed [VEC_W-1:0] xs, ys;

	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in >= 0) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end
		end
	end

endmodule

// File: src/gcb_sincos.sv
// Sine and cosine of a binary angle: quadrant split, a chain of rotation cells, quadrant fold.
// Depends on gcb_pkg and gcb_rot_cell.
module gcb_sincos #(
	parameter int STEPS = gcb_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [31:0]                   ang,
	output logic signed [gcb_pkg::SC_W-1:0] cos_q,
	output logic signed [gcb_pkg::SC_W-1:0] sin_q
);
	import gcb_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic [31:0] qsum, resid;
	logic [1:0]  quad;
	logic signed [SC_W-1:0] x0_q, y0_q;
	logic signed [SZ_W-1:0] z0_q;
	logic signed [SC_W-1:0] x_p [STEPS+1];
	logic signed [SC_W-1:0] y_p [STEPS+1];
	logic signed [SZ_W-1:0] z_p [STEPS+1];
	logic [1:0] quad_p [STEPS+1];
	logic       zero_p [STEPS+1];
	logic signed [SC_W-1:0] xf, yf;

	// Nearest quadrant, residual in [-45, 45) degrees.
	assign qsum  = ang + EIGHTH_TURN;
	assign quad  = qsum[31:30];
	assign resid = ang - {quad, 30'h0};

	always_ff @(posedge clk) begin
		if (en) begin
			x0_q      <= CORDIC_GAIN;
			y0_q      <= '0;
			z0_q      <= $signed(SZ_W'($signed(resid)));
			quad_p[0] <= quad;
			zero_p[0] <= (resid == 32'h0);
			for (int i = 1; i <= STEPS; i++) begin
				quad_p[i] <= quad_p[i-1];
				zero_p[i] <= zero_p[i-1];
			end
		end
	end

	assign x_p[0] = x0_q;
	assign y_p[0] = y0_q;
	assign z_p[0] = z0_q;

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		gcb_rot_cell #(.SHIFT(g)) u_cell (
			.clk  (clk),
			.en   (en),
			.x_in (x_p[g]),
			.y_in (y_p[g]),
			.z_in (z_p[g]),
			.x_q  (x_p[g+1]),
			.y_q  (y_p[g+1]),
			.z_q  (z_p[g+1])
		);
	end

	// A residual of exactly zero takes the exact unit vector instead of the rotated one.
	assign xf = zero_p[STEPS] ? Q30_ONE : x_p[STEPS];
	assign yf = zero_p[STEPS] ? '0 : y_p[STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_p[STEPS])
				QUAD_0: begin cos_q <= xf;  sin_q <= yf;  end
				QUAD_1: begin cos_q <= -yf; sin_q <= xf;  end
				QUAD_2: begin cos_q <= -xf; sin_q <= -yf; end
				QUAD_3: begin cos_q <= yf;  sin_q <= -xf; end
				default: begin cos_q <= xf; sin_q <= yf;  end
			endcase
		end
	end

endmodule
